### rtl/kwm_pkg.sv
// Shared types, codes and default sizes for the k-way sorted list merge
`timescale 1ns / 1ps

package kwm_pkg;

   // default sizes
   localparam int LISTS_DEF      = 8;
   localparam int LIST_DEPTH_DEF = 256;
   localparam int VALUE_BITS_DEF = 32;

   // command codes carried in the input tuser
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // status codes carried in the result tuser
   localparam logic [1:0] ST_POPPED   = 2'd0;
   localparam logic [1:0] ST_ACCEPTED = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // register byte addresses
   localparam logic [1:0] REG_ORDER_DESC = 2'd0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_WB,
      S_RESP
   } kwm_state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  list_id;
      logic [31:0] value;
   } kwm_req_type;

   typedef struct packed {
      logic [31:0] merged_value;
      logic [2:0]  source_list;
      logic [1:0]  status;
   } kwm_rsp_type;

endpackage

### rtl/kwm_data_mem.sv
// Element store: one synchronous RAM holding every list's values
`timescale 1ns / 1ps

module kwm_data_mem #(
   parameter int ADDR_W     = 11,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);
   import kwm_pkg::*;

   logic [VALUE_BITS-1:0] store_ff [2**ADDR_W];
   logic [VALUE_BITS-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/kwm_ptr_mem.sv
// Per-list length and read pointer RAM with per-entry valid bits
`timescale 1ns / 1ps

module kwm_ptr_mem #(
   parameter int LISTS = 8,
   parameter int CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     rd_en,
   input  logic [$clog2(LISTS)-1:0] rd_idx,
   output logic [CNT_W-1:0]         rd_len,
   output logic [CNT_W-1:0]         rd_ptr,
   input  logic                     wr_en,
   input  logic [$clog2(LISTS)-1:0] wr_idx,
   input  logic [CNT_W-1:0]         wr_len,
   input  logic [CNT_W-1:0]         wr_ptr
);
   import kwm_pkg::*;

   logic [2*CNT_W-1:0] entry_ff [LISTS];
   logic [LISTS-1:0]   vld_ff;
   logic [2*CNT_W-1:0] rd_q_ff;
   logic               rd_vld_ff;

   // entry storage, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= {wr_len, wr_ptr};
      end
      if (rd_en) begin
         rd_q_ff <= entry_ff[rd_idx];
      end
   end

   // valid bits: an entry never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (clear) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   assign rd_len = rd_vld_ff ? rd_q_ff[2*CNT_W-1:CNT_W] : '0;
   assign rd_ptr = rd_vld_ff ? rd_q_ff[CNT_W-1:0] : '0;

endmodule

### rtl/kwm_seq.sv
// Command sequencer: loads, pop scan over list heads, clear, result hold
`timescale 1ns / 1ps

module kwm_seq #(
   parameter int LISTS      = 8,
   parameter int LIST_DEPTH = 256,
   parameter int VALUE_BITS = 32,
   parameter int LIST_W     = $clog2(LISTS),
   parameter int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
   parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      order_desc,
   input  logic                      req_valid,
   input  kwm_pkg::kwm_req_type      req,
   output logic                      req_ready,
   output logic                      res_valid,
   output kwm_pkg::kwm_rsp_type      res,
   input  logic                      res_ready,
   // pointer memory
   output logic                      ptr_clear,
   output logic                      ptr_rd_en,
   output logic [LIST_W-1:0]         ptr_rd_idx,
   input  logic [CNT_W-1:0]          ptr_rd_len,
   input  logic [CNT_W-1:0]          ptr_rd_ptr,
   output logic                      ptr_wr_en,
   output logic [LIST_W-1:0]         ptr_wr_idx,
   output logic [CNT_W-1:0]          ptr_wr_len,
   output logic [CNT_W-1:0]          ptr_wr_ptr,
   // element memory
   output logic                      data_wr_en,
   output logic [LIST_W+PTR_W-1:0]   data_wr_addr,
   output logic [VALUE_BITS-1:0]     data_wr_data,
   output logic                      data_rd_en,
   output logic [LIST_W+PTR_W-1:0]   data_rd_addr,
   input  logic [VALUE_BITS-1:0]     data_rd_data
);
   import kwm_pkg::*;

   kwm_state_type         state_ff, state_in;
   logic [LIST_W-1:0]     id_ff, id_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   kwm_rsp_type           res_ff, res_in;
   logic [LIST_W:0]       scan_idx_ff, scan_idx_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [LIST_W-1:0]     s1_idx_ff, s1_idx_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic [LIST_W-1:0]     s2_idx_ff, s2_idx_in;
   logic [CNT_W-1:0]      s2_len_ff, s2_len_in;
   logic [CNT_W-1:0]      s2_ptr_ff, s2_ptr_in;
   logic                  best_found_ff, best_found_in;
   logic [LIST_W-1:0]     best_idx_ff, best_idx_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic [CNT_W-1:0]      best_len_ff, best_len_in;
   logic [CNT_W-1:0]      best_ptr_ff, best_ptr_in;
   logic                  live;
   logic                  better;
   logic                  id_ok;

   assign id_ok = ({29'd0, req.list_id} < 32'(LISTS));

   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      val_in        = val_ff;
      res_in        = res_ff;
      scan_idx_in   = scan_idx_ff;
      s1_vld_in     = 1'b0;
      s1_idx_in     = s1_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      best_len_in   = best_len_ff;
      best_ptr_in   = best_ptr_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      ptr_clear     = 1'b0;
      ptr_rd_en     = 1'b0;
      ptr_rd_idx    = scan_idx_ff[LIST_W-1:0];
      ptr_wr_en     = 1'b0;
      ptr_wr_idx    = id_ff;
      ptr_wr_len    = CNT_W'(ptr_rd_len + 1'b1);
      ptr_wr_ptr    = ptr_rd_ptr;
      data_wr_en    = 1'b0;
      data_wr_addr  = {id_ff, ptr_rd_len[PTR_W-1:0]};
      data_wr_data  = val_ff;

      // scan stage 2: pointer entry back, fetch the head of a live list
      live         = s1_vld_ff && (ptr_rd_ptr < ptr_rd_len);
      data_rd_en   = live;
      data_rd_addr = {s1_idx_ff, ptr_rd_ptr[PTR_W-1:0]};
      s2_vld_in    = live;
      s2_idx_in    = s1_idx_ff;
      s2_len_in    = ptr_rd_len;
      s2_ptr_in    = ptr_rd_ptr;

      // scan stage 3: head value back, keep it if strictly better
      better = order_desc ? ($signed(data_rd_data) > $signed(best_val_ff))
                          : ($signed(data_rd_data) < $signed(best_val_ff));
      if (s2_vld_ff && (!best_found_ff || better)) begin
         best_found_in = 1'b1;
         best_idx_in   = s2_idx_ff;
         best_val_in   = data_rd_data;
         best_len_in   = s2_len_ff;
         best_ptr_in   = s2_ptr_ff;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in = '{merged_value: '0, source_list: '0, status: ST_ACCEPTED};
               case (req.cmd)
                  CMD_LOAD: begin
                     id_in  = LIST_W'(req.list_id);
                     val_in = VALUE_BITS'($signed(req.value));
                     if (id_ok) begin
                        ptr_rd_en  = 1'b1;
                        ptr_rd_idx = LIST_W'(req.list_id);
                        state_in   = S_LOAD;
                     end else begin
                        res_in.status = ST_FULL;
                        state_in      = S_RESP;
                     end
                  end
                  CMD_POP: begin
                     scan_idx_in   = '0;
                     best_found_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  CMD_CLEAR: begin
                     ptr_clear = 1'b1;
                     state_in  = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         // append at the tail unless the list is full
         S_LOAD: begin
            if (ptr_rd_len >= CNT_W'(LIST_DEPTH)) begin
               res_in.status = ST_FULL;
            end else begin
               data_wr_en    = 1'b1;
               ptr_wr_en     = 1'b1;
               res_in.status = ST_ACCEPTED;
            end
            state_in = S_RESP;
         end
         // scan stage 1: one pointer entry read per cycle
         S_SCAN: begin
            if (scan_idx_ff < (LIST_W+1)'(LISTS)) begin
               ptr_rd_en   = 1'b1;
               ptr_rd_idx  = scan_idx_ff[LIST_W-1:0];
               s1_vld_in   = 1'b1;
               s1_idx_in   = scan_idx_ff[LIST_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = S_WB;
            end
         end
         // advance the winning list
         S_WB: begin
            if (best_found_ff) begin
               ptr_wr_en  = 1'b1;
               ptr_wr_idx = best_idx_ff;
               ptr_wr_len = best_len_ff;
               ptr_wr_ptr = CNT_W'(best_ptr_ff + 1'b1);
               res_in = '{merged_value: 32'($signed(best_val_ff)),
                          source_list:  3'(best_idx_ff),
                          status:       ST_POPPED};
            end else begin
               res_in = '{merged_value: '0, source_list: '0, status: ST_NONE};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   // payload and scan bookkeeping
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      val_ff        <= val_in;
      res_ff        <= res_in;
      scan_idx_ff   <= scan_idx_in;
      s1_idx_ff     <= s1_idx_in;
      s2_idx_ff     <= s2_idx_in;
      s2_len_ff     <= s2_len_in;
      s2_ptr_ff     <= s2_ptr_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      best_len_ff   <= best_len_in;
      best_ptr_ff   <= best_ptr_in;
   end

endmodule

### rtl/k_way_sorted_list_merge.sv
// Top level of the k-way sorted list merge
`timescale 1ns / 1ps
//
// Holds LISTS signed lists in one element RAM and merges their heads on demand.
// Input beats (req_) carry a command in tuser: load appends tdata's value to
// list list_id, pop returns the best head over all lists and advances that
// list, clear empties every list. Each input beat gives exactly one result
// beat (rsp_) with a status in tuser: popped, accepted, nothing left, or
// list full (a load to a full or nonexistent list is dropped).
// order_desc (csr address 0) picks smallest-first (0) or largest-first (1);
// write it only while the block is idle.
// Timing: one command at a time. A pop scans the pointer RAM one list per
// cycle and fetches each live head from the element RAM through a
// three-stage read pipeline.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls further, the finished result of the following
// command is held inside and req_tready stays low until the slot drains.
// Reset (synchronous, active high) empties all lists and sets ascending order.
//
module k_way_sorted_list_merge #(
   parameter int LISTS      = kwm_pkg::LISTS_DEF,
   parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // list_id[2:0], value[34:3], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // merged_value[31:0], source_list[34:32], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kwm_pkg::*;

   localparam int LIST_W = $clog2(LISTS);
   localparam int PTR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

   kwm_req_type           req;
   kwm_rsp_type           res;
   logic                  res_valid;
   logic                  res_ready;
   logic                  order_desc_ff;
   logic                  rsp_valid_ff;
   kwm_rsp_type           rsp_ff;
   logic                  ptr_clear;
   logic                  ptr_rd_en;
   logic [LIST_W-1:0]     ptr_rd_idx;
   logic [CNT_W-1:0]      ptr_rd_len;
   logic [CNT_W-1:0]      ptr_rd_ptr;
   logic                  ptr_wr_en;
   logic [LIST_W-1:0]     ptr_wr_idx;
   logic [CNT_W-1:0]      ptr_wr_len;
   logic [CNT_W-1:0]      ptr_wr_ptr;
   logic                  data_wr_en;
   logic [LIST_W+PTR_W-1:0] data_wr_addr;
   logic [VALUE_BITS-1:0] data_wr_data;
   logic                  data_rd_en;
   logic [LIST_W+PTR_W-1:0] data_rd_addr;
   logic [VALUE_BITS-1:0] data_rd_data;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_ORDER_DESC) ? {31'd0, order_desc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_desc_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == REG_ORDER_DESC) begin
         order_desc_ff <= csr_pwdata[0];
      end
   end

   // input beat unpacking
   assign req.cmd     = req_tuser;
   assign req.list_id = req_tdata[2:0];
   assign req.value   = req_tdata[34:3];

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.source_list, rsp_ff.merged_value};
   assign rsp_tuser  = rsp_ff.status;

   kwm_seq #(
      .LISTS      (LISTS),
      .LIST_DEPTH (LIST_DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .LIST_W     (LIST_W),
      .PTR_W      (PTR_W),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .order_desc   (order_desc_ff),
      .req_valid    (req_tvalid),
      .req          (req),
      .req_ready    (req_tready),
      .res_valid    (res_valid),
      .res          (res),
      .res_ready    (res_ready),
      .ptr_clear    (ptr_clear),
      .ptr_rd_en    (ptr_rd_en),
      .ptr_rd_idx   (ptr_rd_idx),
      .ptr_rd_len   (ptr_rd_len),
      .ptr_rd_ptr   (ptr_rd_ptr),
      .ptr_wr_en    (ptr_wr_en),
      .ptr_wr_idx   (ptr_wr_idx),
      .ptr_wr_len   (ptr_wr_len),
      .ptr_wr_ptr   (ptr_wr_ptr),
      .data_wr_en   (data_wr_en),
      .data_wr_addr (data_wr_addr),
      .data_wr_data (data_wr_data),
      .data_rd_en   (data_rd_en),
      .data_rd_addr (data_rd_addr),
      .data_rd_data (data_rd_data)
   );

   kwm_ptr_mem #(
      .LISTS (LISTS),
      .CNT_W (CNT_W)
   ) u_ptr_mem (
      .clock  (clock),
      .reset  (reset),
      .clear  (ptr_clear),
      .rd_en  (ptr_rd_en),
      .rd_idx (ptr_rd_idx),
      .rd_len (ptr_rd_len),
      .rd_ptr (ptr_rd_ptr),
      .wr_en  (ptr_wr_en),
      .wr_idx (ptr_wr_idx),
      .wr_len (ptr_wr_len),
      .wr_ptr (ptr_wr_ptr)
   );

   kwm_data_mem #(
      .ADDR_W     (LIST_W + PTR_W),
      .VALUE_BITS (VALUE_BITS)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_data)
   );

`ifndef SYNTH
   // one command in flight: no beat is taken right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input beat taken while a command is in flight");

   // a held result blocks new commands
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready)
      else $error("input ready while a result is held");

   // results other than a pop carry zero value and source
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status != ST_POPPED) |->
         (rsp_ff.merged_value == 32'd0 && rsp_ff.source_list == 3'd0))
      else $error("non-pop result with nonzero payload");
`endif

endmodule

### sim/tb_k_way_sorted_list_merge.sv
// Self-checking testbench for the k-way sorted list merge with stream ports and a csr port
`timescale 1ns / 1ps

module tb_k_way_sorted_list_merge;
   import kwm_pkg::*;

   localparam int NUM_LISTS    = kwm_pkg::LISTS_DEF;
   localparam int DEPTH        = kwm_pkg::LIST_DEPTH_DEF;
   localparam int MAX_RUN      = 12;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_REPORTS  = 100;
   localparam int SETTLE       = NUM_LISTS + 10;

   // command code the block does not define
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // list_id[2:0], value[34:3], zero pad
   logic [1:0]  req_tuser = '0;    // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // merged_value[31:0], source_list[34:32], zero pad
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [31:0] list_mem [NUM_LISTS][DEPTH];
   int          list_fill [NUM_LISTS];
   int          list_rd [NUM_LISTS];
   logic        merge_desc = 1'b0;

   kwm_rsp_type expected_beats [$];
   kwm_rsp_type want_beat;
   int          fail_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          tx_idle_pct = 22;
   int          rx_idle_pct = 79;
   int          rx_hold_req = 0;
   int          rx_hold_left = 0;

   k_way_sorted_list_merge uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // expected result of one command, updates the list state
   function automatic kwm_rsp_type predict_merge_result(input logic [1:0] cmd,
                                                         input logic [2:0] id,
                                                         input logic [31:0] val);
      kwm_rsp_type r;
      logic        found;
      int          best;
      logic [31:0] head;
      logic [31:0] cand;
      r = '0;
      r.status = ST_ACCEPTED;
      found = 1'b0;
      best = 0;
      head = '0;
      case (cmd)
         CMD_LOAD: begin
            if (int'(id) >= NUM_LISTS || list_fill[id] >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_mem[id][list_fill[id]] = val;
               list_fill[id]++;
            end
         end
         CMD_POP: begin
            // best live head, lowest list wins a tie
            for (int i = 0; i < NUM_LISTS; i++) begin
               if (list_rd[i] < list_fill[i]) begin
                  cand = list_mem[i][list_rd[i]];
                  if (!found || (merge_desc ? $signed(cand) > $signed(head)
                                            : $signed(cand) < $signed(head))) begin
                     found = 1'b1;
                     best = i;
                     head = cand;
                  end
               end
            end
            if (found) begin
               list_rd[best]++;
               r.merged_value = head;
               r.source_list = 3'(best);
               r.status = ST_POPPED;
            end else begin
               r.status = ST_NONE;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               list_fill[i] = 0;
               list_rd[i] = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rx_hold_req > 0) begin
         rx_hold_left = rx_hold_req;
         rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rx_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endtask

   // result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $error("result beat with nothing expected: tdata %h tuser %h",
                      rsp_tdata, rsp_tuser);
         end else begin
            want_beat = expected_beats.pop_front();
            if (rsp_tdata[31:0] !== want_beat.merged_value)
               report_field("merged_value", want_beat.merged_value, rsp_tdata[31:0]);
            if (rsp_tdata[34:32] !== want_beat.source_list)
               report_field("source_list", 32'(want_beat.source_list), 32'(rsp_tdata[34:32]));
            if (rsp_tuser !== want_beat.status)
               report_field("status", 32'(want_beat.status), 32'(rsp_tuser));
         end
      end
   end

   // offer one beat, with a random gap first, and predict it once taken
   task automatic send_item(input logic [1:0] cmd, input logic [2:0] id,
                            input logic [31:0] val);
      kwm_rsp_type pred;
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, val, id};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_merge_result(cmd, id, val);
      expected_beats = {expected_beats, pred};
      items_sent++;
   endtask

   // stop offering and let every expected result drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == REG_ORDER_DESC)
         merge_desc = data[0];
   endtask

   // extremes and small values that tie often, plus plain random values
   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         1, 2: return $urandom_range(0, 6) - 3;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      // nothing loaded yet, then an undefined command
      send_item(CMD_POP, 3'd0, 32'd0);
      send_item(CMD_UNKNOWN, 3'd7, 32'hffff_ffff);
      // field extremes and ties across lists
      send_item(CMD_LOAD, 3'd0, 32'h8000_0000);
      send_item(CMD_LOAD, 3'd7, 32'h7fff_ffff);
      send_item(CMD_LOAD, 3'd3, 32'hffff_ffff);
      send_item(CMD_LOAD, 3'd3, 32'd5);
      send_item(CMD_LOAD, 3'd1, 32'd0);
      send_item(CMD_LOAD, 3'd0, 32'd0);
      send_item(CMD_LOAD, 3'd2, 32'd5);
      // seven pops drain everything, the eighth finds nothing
      repeat (8) send_item(CMD_POP, 3'd7, 32'hffff_ffff);
      // exhausted list comes back to life
      send_item(CMD_LOAD, 3'd3, 32'd42);
      send_item(CMD_POP, 3'd0, 32'd0);
      // unsorted list pops in load order
      send_item(CMD_LOAD, 3'd4, 32'd9);
      send_item(CMD_LOAD, 3'd4, 32'd2);
      send_item(CMD_POP, 3'd0, 32'd0);
      send_item(CMD_POP, 3'd0, 32'd0);
      // clear drops pending data
      send_item(CMD_LOAD, 3'd6, 32'd7);
      send_item(CMD_CLEAR, 3'd5, 32'h1234_5678);
      send_item(CMD_POP, 3'd0, 32'd0);
      wait_idle();
   endtask

   task automatic test_list_full();
      send_item(CMD_CLEAR, 3'd0, 32'd0);
      for (int i = 0; i < DEPTH; i++)
         send_item(CMD_LOAD, 3'd5, 32'(i * 16 - 2048));
      send_item(CMD_LOAD, 3'd5, 32'd1);
      repeat (3) send_item(CMD_POP, 3'd0, 32'd0);
      // pops do not free room
      send_item(CMD_LOAD, 3'd5, 32'd2);
      send_item(CMD_LOAD, 3'd2, 32'h8000_0000);
      repeat (4) send_item(CMD_POP, 3'd0, 32'd0);
      send_item(CMD_CLEAR, 3'd0, 32'd0);
      send_item(CMD_LOAD, 3'd5, 32'd3);
      send_item(CMD_POP, 3'd0, 32'd0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // receiver holds off long enough for the input to stall
      rx_hold_req = 400;
      for (int i = 0; i < 12; i++)
         send_item(CMD_LOAD, 3'(i % NUM_LISTS), $urandom());
      repeat (12) send_item(CMD_POP, 3'($urandom_range(0, 7)), $urandom());
      send_item(CMD_CLEAR, 3'd0, 32'd0);
      wait_idle();
   endtask

   // load runs, usually sorted, into random lists, interleaved, then pop them all
   task automatic run_merge_round();
      logic [31:0] pend [NUM_LISTS][MAX_RUN];
      int          cnt [NUM_LISTS];
      int          taken [NUM_LISTS];
      int          total;
      int          pick;
      int          lst;
      int          pos;
      logic        sorted_run;
      logic        mix_pops;
      logic [31:0] v;
      sorted_run = ($urandom_range(0, 7) != 0);
      mix_pops = ($urandom_range(0, 3) == 0);
      total = 0;
      if ($urandom_range(0, 1) == 1)
         send_item(CMD_CLEAR, 3'($urandom_range(0, 7)), $urandom());
      for (int i = 0; i < NUM_LISTS; i++) begin
         cnt[i] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, MAX_RUN));
         taken[i] = 0;
         for (int k = 0; k < cnt[i]; k++) begin
            v = rand_elem();
            pos = k;
            // insertion into the run in the current merge order
            while (sorted_run && pos > 0 &&
                   (merge_desc ? $signed(pend[i][pos-1]) < $signed(v)
                               : $signed(pend[i][pos-1]) > $signed(v))) begin
               pend[i][pos] = pend[i][pos-1];
               pos--;
            end
            pend[i][pos] = v;
         end
         total += cnt[i];
      end
      for (int n = total; n > 0; n--) begin
         pick = $urandom_range(0, n - 1);
         lst = 0;
         while (pick >= cnt[lst] - taken[lst]) begin
            pick -= cnt[lst] - taken[lst];
            lst++;
         end
         send_item(CMD_LOAD, 3'(lst), pend[lst][taken[lst]]);
         taken[lst]++;
         if (mix_pops && $urandom_range(0, 3) == 0)
            send_item(CMD_POP, 3'($urandom_range(0, 7)), $urandom());
      end
      repeat (total + $urandom_range(0, 2))
         send_item(CMD_POP, 3'($urandom_range(0, 7)), $urandom());
   endtask

   task automatic test_random_merge();
      int phase_start;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin tx_idle_pct = 22; rx_idle_pct = 79; end
            1: begin tx_idle_pct = 79; rx_idle_pct = 22; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         wait_idle();
         csr_write(REG_ORDER_DESC, (p % 2 == 0) ? 32'd1 : 32'd0);
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
            if ($urandom_range(0, 4) != 0) begin
               run_merge_round();
            end else begin
               // noise: any command with any fields
               repeat ($urandom_range(1, 8))
                  send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom());
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         list_fill[i] = 0;
         list_rd[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_list_full();
      test_random_merge();
      test_backpressure();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
